// File: design/rrle_pkg.sv
// Shared types and character codes for the range/repeat list expander.
// No dependencies; imported by every module of the block.
`default_nettype none
package rrle_pkg;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam int         DIGIT_BITS = 6;
   localparam int         VALUE_W    = 16;

   // Commands from the sequencer to the item state registers.
   typedef struct packed {
      logic digit;    // fold char into the accumulator
      logic tilde;    // range start separator
      logic star;     // repeat separator
      logic close;    // item finished at a comma
      logic clear;    // row finished, back to reset state
      logic count;    // one element emitted
   } regs_cmd_type;

   // Item state seen by the sequencer, plus the shared adder's result.
   typedef struct packed {
      logic [VALUE_W-1:0] accum;
      logic [VALUE_W-1:0] range_start;
      logic [VALUE_W-1:0] second_value;
      logic               in_range;
      logic               in_repeat;
      logic [VALUE_W-1:0] row_count;
      logic [VALUE_W-1:0] sum;
   } regs_stat_type;

   // One result beat handed to the output register.
   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
      logic               row_end;
      logic               last;
      logic               trunc;
   } push_type;

endpackage
`default_nettype wire

// File: design/rrle_regs.sv
// Item state registers of the list expander and the shared 16-bit adder.
// Depends on rrle_pkg; driven by commands from rrle_seq.
`default_nettype none
module rrle_regs
   import rrle_pkg::*;
#(
   parameter int CNT_W = 7
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         char_in,
   input  wire logic [CNT_W-1:0]   idx,
   input  wire regs_cmd_type       cmd,
   output regs_stat_type           stat
);

   logic [VALUE_W-1:0] accum_ff, accum_in;
   logic [VALUE_W-1:0] range_start_ff, range_start_in;
   logic [VALUE_W-1:0] second_value_ff, second_value_in;
   logic               in_range_ff, in_range_in;
   logic               in_repeat_ff, in_repeat_in;
   logic [VALUE_W-1:0] row_count_ff, row_count_in;
   logic [VALUE_W-1:0] add_a, add_b, sum;

   // The one adder serves the digit fold and the element value.
   always_comb begin
      if (cmd.digit) begin
         add_a = accum_ff << DIGIT_BITS;
         add_b = {8'h00, char_in} - {8'h00, CHAR_ZERO};
      end else if (in_range_ff) begin
         add_a = range_start_ff;
         add_b = VALUE_W'(idx);
      end else if (in_repeat_ff) begin
         add_a = second_value_ff;
         add_b = '0;
      end else begin
         add_a = accum_ff;
         add_b = '0;
      end
      sum = add_a + add_b;
   end

   always_comb begin
      accum_in        = accum_ff;
      range_start_in  = range_start_ff;
      second_value_in = second_value_ff;
      in_range_in     = in_range_ff;
      in_repeat_in    = in_repeat_ff;
      row_count_in    = row_count_ff;
      if (cmd.count) begin
         row_count_in = row_count_ff + VALUE_W'(1);
      end
      if (cmd.clear) begin
         accum_in        = '0;
         range_start_in  = '0;
         second_value_in = '0;
         in_range_in     = 1'b0;
         in_repeat_in    = 1'b0;
         row_count_in    = '0;
      end else if (cmd.tilde) begin
         range_start_in  = accum_ff;
         second_value_in = '0;
         in_range_in     = 1'b1;
         accum_in        = '0;
      end else if (cmd.star) begin
         second_value_in = accum_ff;
         in_repeat_in    = 1'b1;
         accum_in        = '0;
      end else if (cmd.digit) begin
         accum_in = sum;
      end else if (cmd.close) begin
         if (in_range_ff && !in_repeat_ff) begin
            second_value_in = accum_ff;
         end
         accum_in     = '0;
         in_range_in  = 1'b0;
         in_repeat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff        <= '0;
         range_start_ff  <= '0;
         second_value_ff <= '0;
         in_range_ff     <= 1'b0;
         in_repeat_ff    <= 1'b0;
         row_count_ff    <= '0;
      end else begin
         accum_ff        <= accum_in;
         range_start_ff  <= range_start_in;
         second_value_ff <= second_value_in;
         in_range_ff     <= in_range_in;
         in_repeat_ff    <= in_repeat_in;
         row_count_ff    <= row_count_in;
      end
   end

   assign stat.accum        = accum_ff;
   assign stat.range_start  = range_start_ff;
   assign stat.second_value = second_value_ff;
   assign stat.in_range     = in_range_ff;
   assign stat.in_repeat    = in_repeat_ff;
   assign stat.row_count    = row_count_ff;
   assign stat.sum          = sum;

endmodule
`default_nettype wire

// File: design/rrle_seq.sv
// Sequencer of the list expander: character decode, expansion length and
// the element emission loop. Depends on rrle_pkg; drives rrle_regs.
`default_nettype none
module rrle_seq
   import rrle_pkg::*;
#(
   parameter int MAX_EXPAND = 64,
   parameter int CNT_W      = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [7:0]       char_in,
   input  wire logic             out_free,
   input  wire regs_stat_type    stat,
   output regs_cmd_type          cmd,
   output logic [CNT_W-1:0]      idx,
   output push_type              push
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;
   localparam logic [2:0] ST_ROWEND = 3'd4;

   localparam int TOT_W = 2 * VALUE_W + 1;

   logic [2:0]         state_ff, state_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   emit_ff, emit_in;
   logic               trunc_ff, trunc_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   r_ff, r_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               accepted;
   logic               is_term, is_tilde, is_star, is_comma;
   logic [TOT_W-1:0]   product;
   logic [VALUE_W-1:0] reps;
   logic               at_last;

   assign in_ready  = (state_ff == ST_IDLE);
   assign accepted  = in_valid && in_ready;
   assign is_term   = (char_in <= CHAR_SPACE);
   assign is_tilde  = (char_in == CHAR_TILDE);
   assign is_star   = (char_in == CHAR_STAR);
   assign is_comma  = (char_in == CHAR_COMMA);

   // Range with repeat: (length + 1) * count elements.
   assign product = TOT_W'({1'b0, stat.second_value} + 17'd1) * TOT_W'(stat.accum);
   // A plain range steps its index on every element.
   assign reps    = stat.in_repeat ? stat.accum : VALUE_W'(1);
   assign at_last = ((k_ff + CNT_W'(1)) == emit_ff);
   assign idx     = idx_ff;

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      emit_in  = emit_ff;
      trunc_in = trunc_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      push     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accepted) begin
               if (is_term) begin
                  state_in = ST_ROWEND;
               end else if (is_tilde) begin
                  cmd.tilde = 1'b1;
               end else if (is_star) begin
                  cmd.star = 1'b1;
               end else if (is_comma) begin
                  state_in = ST_LOAD;
               end else begin
                  cmd.digit = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            if (!stat.in_range && !stat.in_repeat) begin
               total_in = TOT_W'(1);
            end else if (!stat.in_repeat) begin
               total_in = TOT_W'(stat.accum) + TOT_W'(1);
            end else if (!stat.in_range) begin
               total_in = TOT_W'(stat.accum);
            end else begin
               total_in = product;
            end
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            trunc_in = (total_ff > TOT_W'(MAX_EXPAND));
            emit_in  = trunc_in ? CNT_W'(MAX_EXPAND) : total_ff[CNT_W-1:0];
            k_in     = '0;
            r_in     = '0;
            idx_in   = '0;
            if (total_ff == '0) begin
               cmd.close = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               push.valid   = 1'b1;
               push.value   = stat.sum;
               push.row_end = 1'b0;
               push.last    = at_last;
               push.trunc   = trunc_ff;
               cmd.count    = 1'b1;
               if (at_last) begin
                  cmd.close = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  k_in = k_ff + CNT_W'(1);
                  if (VALUE_W'(r_ff + CNT_W'(1)) == reps) begin
                     r_in   = '0;
                     idx_in = idx_ff + CNT_W'(1);
                  end else begin
                     r_in = r_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_ROWEND: begin
            if (out_free) begin
               push.valid   = 1'b1;
               push.value   = stat.row_count;
               push.row_end = 1'b1;
               push.last    = 1'b1;
               push.trunc   = 1'b0;
               cmd.clear    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      emit_ff  <= emit_in;
      trunc_ff <= trunc_in;
      k_ff     <= k_in;
      r_ff     <= r_in;
      idx_ff   <= idx_in;
   end

endmodule
`default_nettype wire

// File: design/range_repeat_list_expander.sv
// Top level of the range/repeat list expander: ports and result register.
// Depends on rrle_pkg, rrle_regs and rrle_seq.
//
// The req_ channel takes one character of a compressed index row per beat.
// Digit characters fold into a 16-bit accumulator, '~' and '*' mark a range
// start and a repeat, ',' expands the item into list elements, and any
// character at or below space ends the row with one beat carrying the
// row's element count (rsp_tuser bit 0 set), after which all state is zero.
// Every result beat leaves through rsp_; rsp_tlast marks the last beat that
// one character caused, and rsp_tuser bit 1 flags an expansion cut short
// at MAX_EXPAND elements.
//
// Digits and separators update the item state as they are accepted. A comma
// passes through a load state, which works out the expansion length (with
// the multiply of range length by repeat count), and a check state, then
// emits its elements; a row end passes through a row-end state. The emission
// loop shares one adder with the digit fold, so one element leaves per cycle
// while the receiver takes beats. req_tready is low while an item is being expanded.
// Results sit in an output register; when the receiver stalls, the
// expansion holds and resumes as soon as the beat is taken. Reset is
// synchronous and clears the sequencer state, the item state and the output valid flag.
`default_nettype none
module range_repeat_list_expander
   import rrle_pkg::*;
#(
   parameter int MAX_EXPAND = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] char_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,    // [15:0] value
   output logic             rsp_tlast,    // run_last
   output logic [1:0]       rsp_tuser     // [0] row_end, [1] truncated
);

   // Counters must hold MAX_EXPAND itself.
   localparam int CNT_W = $clog2(MAX_EXPAND + 1);

   regs_cmd_type       cmd;
   regs_stat_type      stat;
   push_type           push;
   logic [CNT_W-1:0]   idx;
   logic               out_free;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_last_ff;
   logic [1:0]         rsp_user_ff;

   // The output register can take a new beat when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   rrle_regs #(
      .CNT_W (CNT_W)
   ) u_regs (
      .clock   (clock),
      .reset   (reset),
      .char_in (req_tdata),
      .idx     (idx),
      .cmd     (cmd),
      .stat    (stat)
   );

   rrle_seq #(
      .MAX_EXPAND (MAX_EXPAND),
      .CNT_W      (CNT_W)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .char_in  (req_tdata),
      .out_free (out_free),
      .stat     (stat),
      .cmd      (cmd),
      .idx      (idx),
      .push     (push)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rsp_value_ff <= push.value;
         rsp_last_ff  <= push.last;
         rsp_user_ff  <= {push.trunc, push.row_end};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for range_repeat_list_expander: directed table plus random rows.
// Depends on rrle_pkg and the block's RTL; prediction is built in, no files are read.
module tb_top;
   import rrle_pkg::*;

   localparam int          MAX_EXPAND = 64;
   localparam logic [7:0]  CHAR_NUL   = 8'h00;   // lowest row terminator
   localparam logic [7:0]  CHAR_BANG  = 8'h21;   // lowest non-terminator, below '0'
   localparam logic [7:0]  CHAR_TOP   = 8'hFF;   // high characters count as digits

   // One list element as it leaves the block.
   typedef struct packed {
      logic [15:0] value;
      logic        row_end;
      logic        last;
      logic        trunc;
   } elem_type;

   // One input beat. When typed is set, the expected single result is given
   // right here instead of being taken from the predictor.
   typedef struct packed {
      logic [7:0]  ch;
      logic        typed;
      logic [15:0] value;
      logic        row_end;
      logic        last;
      logic        trunc;
   } char_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] char_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [15:0] value
   logic        rsp_tlast;            // run_last
   logic [1:0]  rsp_tuser;            // [0] row_end, [1] truncated

   // Expected elements in arrival order, and the ones the latest character produced.
   elem_type       pending_elems[$];
   elem_type       char_elems[$];
   char_beat_type  char_stream[$];
   int             mismatch_count = 0;

   // Idle control: quiet_phase is shared by both sides, stall_left is the receiver's alone.
   // During a quiet phase neither side stalls, so back-to-back traffic gets exercised as well.
   bit          quiet_phase = 1'b0;
   int          stall_left  = 0;

   // Mirror of the block's item state.
   logic [15:0] acc_m, start_m, second_m, row_cnt_m;
   logic        range_m, repeat_m;

   always #5 clock = ~clock;

   range_repeat_list_expander #(.MAX_EXPAND(MAX_EXPAND)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Directed rows. Typed expectations: the row count right after reset, a
   // single plain value, and the final count of the row, which adds up
   // 1 + 4 + 2 + 6 + 64 elements (the pending '4' is dropped).
   char_beat_type directed_rows [0:25] = '{
      '{CHAR_SPACE,        1'b1, 16'd0,  1'b1, 1'b1, 1'b0},  // empty row
      '{CHAR_ZERO + 8'd5,  1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_COMMA,        1'b1, 16'd5,  1'b0, 1'b1, 1'b0},  // plain value
      '{CHAR_ZERO + 8'd1,  1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_TILDE,        1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_ZERO + 8'd3,  1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_COMMA,        1'b0, 16'd0,  1'b0, 1'b0, 1'b0},  // range 1..4
      '{CHAR_ZERO + 8'd7,  1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_STAR,         1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_ZERO + 8'd2,  1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_COMMA,        1'b0, 16'd0,  1'b0, 1'b0, 1'b0},  // 7 twice
      '{CHAR_ZERO + 8'd2,  1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_TILDE,        1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_ZERO + 8'd1,  1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_STAR,         1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_ZERO + 8'd3,  1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_COMMA,        1'b0, 16'd0,  1'b0, 1'b0, 1'b0},  // 2,2,2,3,3,3
      '{CHAR_BANG,         1'b0, 16'd0,  1'b0, 1'b0, 1'b0},  // digit below '0'
      '{CHAR_TILDE,        1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_TOP,          1'b0, 16'd0,  1'b0, 1'b0, 1'b0},  // high character as digit
      '{CHAR_COMMA,        1'b0, 16'd0,  1'b0, 1'b0, 1'b0},  // wraps past 65535, cut short
      '{CHAR_ZERO + 8'd9,  1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_STAR,         1'b0, 16'd0,  1'b0, 1'b0, 1'b0},
      '{CHAR_COMMA,        1'b0, 16'd0,  1'b0, 1'b0, 1'b0},  // repeat count zero: nothing
      '{CHAR_ZERO + 8'd4,  1'b0, 16'd0,  1'b0, 1'b0, 1'b0},  // pending value, dropped
      '{CHAR_NUL,          1'b1, 16'd77, 1'b1, 1'b1, 1'b0}
   };

   // Works out the elements one accepted character produces and advances
   // the mirrored state. Results land in char_elems.
   task automatic expand_char(input logic [7:0] c);
      longint unsigned total, emit, k;
      logic [15:0]     reps, v;
      logic            cut;
      char_elems.delete();
      if (c <= CHAR_SPACE) begin
         char_elems.insert(char_elems.size(), elem_type'{row_cnt_m, 1'b1, 1'b1, 1'b0});
         acc_m     = '0;
         start_m   = '0;
         second_m  = '0;
         row_cnt_m = '0;
         range_m   = 1'b0;
         repeat_m  = 1'b0;
      end else if (c == CHAR_TILDE) begin
         start_m  = acc_m;
         second_m = '0;
         range_m  = 1'b1;
         acc_m    = '0;
      end else if (c == CHAR_STAR) begin
         second_m = acc_m;
         acc_m    = '0;
         repeat_m = 1'b1;
      end else if (c != CHAR_COMMA) begin
         acc_m = (acc_m << DIGIT_BITS) + c - CHAR_ZERO;
      end else begin
         reps = acc_m;
         if (!range_m && !repeat_m)
            total = 1;
         else if (!repeat_m)
            total = longint'(acc_m) + 1;
         else if (!range_m)
            total = reps;
         else
            total = (longint'(second_m) + 1) * longint'(reps);
         cut  = (total > MAX_EXPAND);
         emit = cut ? MAX_EXPAND : total;
         for (k = 0; k < emit; k++) begin
            if (!range_m && !repeat_m)
               v = acc_m;
            else if (!repeat_m)
               v = start_m + 16'(k);
            else if (!range_m)
               v = second_m;
            else
               v = start_m + 16'(k / reps);
            char_elems.insert(char_elems.size(), elem_type'{v, 1'b0, (k + 1 == emit), cut});
         end
         if (!repeat_m && range_m)
            second_m = acc_m;
         row_cnt_m = row_cnt_m + 16'(emit);
         acc_m     = '0;
         range_m   = 1'b0;
         repeat_m  = 1'b0;
      end
   endtask

   // Idle lengths: short in 17 of 20 picks, now and then a long one.
   function automatic int pick_pause();
      if ($urandom_range(0, 19) < 17)
         return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   task automatic add_char(input logic [7:0] c);
      char_stream.insert(char_stream.size(),
                         char_beat_type'{c, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0});
   endtask

   // Writes a value as base-64 digits, most significant first, sometimes
   // with a leading zero digit.
   task automatic add_number(input logic [15:0] v);
      int ndig;
      ndig = (v < 64) ? 1 : (v < 4096) ? 2 : 3;
      if ($urandom_range(0, 7) == 0)
         ndig++;
      for (int i = ndig - 1; i >= 0; i--)
         add_char(CHAR_ZERO + 8'((32'(v) >> (DIGIT_BITS * i)) & 32'h3F));
   endtask

   function automatic logic [15:0] pick_start();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(65500, 65535));  // wraps inside a range
         1:       return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 63));
      endcase
   endfunction

   // Range lengths and repeat counts: small mostly, some near the
   // truncation edge, a few anywhere in 16 bits.
   function automatic logic [15:0] pick_count(input int small_max);
      int r;
      r = $urandom_range(0, 19);
      if (r < 15)
         return 16'($urandom_range(0, small_max));
      if (r < 18)
         return 16'($urandom_range(MAX_EXPAND - 4, MAX_EXPAND + 4));
      return 16'($urandom_range(0, 65535));
   endfunction

   // One random row: a few well-formed items with random content, an
   // occasional broken stretch, sometimes a dangling value, then a terminator.
   task automatic add_row();
      int r;
      repeat ($urandom_range(1, 4)) begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            add_number(pick_start());
         end else if (r < 45) begin
            add_number(pick_start());
            add_char(CHAR_TILDE);
            add_number(pick_count(8));
         end else if (r < 65) begin
            add_number(pick_start());
            add_char(CHAR_STAR);
            add_number(pick_count(5));
         end else if (r < 85) begin
            add_number(pick_start());
            add_char(CHAR_TILDE);
            add_number(pick_count(4));
            add_char(CHAR_STAR);
            add_number(pick_count(4));
         end else begin
            // Broken item: separators in odd order and arbitrary bytes.
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 3))
                  0:       add_char(CHAR_TILDE);
                  1:       add_char(CHAR_STAR);
                  2:       add_char(CHAR_COMMA);
                  default: add_char(8'($urandom_range(0, 255)));
               endcase
            end
         end
         add_char(CHAR_COMMA);
      end
      if ($urandom_range(0, 4) == 0)
         add_number(pick_start());
      add_char(8'($urandom_range(0, CHAR_SPACE)));
   endtask

   // Receiver side: random stalls, and a slow toggle of the quiet phase.
   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0)
         quiet_phase <= !quiet_phase;
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_pause() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker: every accepted beat is matched against the oldest
   // expected element.
   always @(posedge clock) begin
      elem_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]};
         if (pending_elems.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected beat value=%h row_end=%b last=%b trunc=%b",
                        $realtime, got.value, got.row_end, got.last, got.trunc);
            mismatch_count++;
         end else begin
            want = pending_elems.pop_front();
            if (got !== want) begin
               if (mismatch_count < 10)
                  $display("%0t: mismatch expected %h/%b/%b/%b got %h/%b/%b/%b",
                           $realtime, want.value, want.row_end, want.last, want.trunc,
                           got.value, got.row_end, got.last, got.trunc);
               mismatch_count++;
            end
         end
      end
   end

   // Sender: builds the whole character stream, releases reset, then offers
   // one beat at a time. The predictor runs at the edge where a beat is taken.
   initial begin
      char_beat_type beat;
      int            gap;
      acc_m     = '0;
      start_m   = '0;
      second_m  = '0;
      row_cnt_m = '0;
      range_m   = 1'b0;
      repeat_m  = 1'b0;
      foreach (directed_rows[i])
         char_stream.insert(char_stream.size(), directed_rows[i]);
      while (char_stream.size() < 250)
         add_row();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (char_stream.size() != 0) begin
         beat = char_stream.pop_front();
         gap  = (!quiet_phase && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= beat.ch;
         do
            @(posedge clock);
         while (!req_tready);
         expand_char(beat.ch);
         if (beat.typed)
            pending_elems.insert(pending_elems.size(),
                                 elem_type'{beat.value, beat.row_end, beat.last, beat.trunc});
         else
            foreach (char_elems[i])
               pending_elems.insert(pending_elems.size(), char_elems[i]);
      end
      req_tvalid <= 1'b0;

      // Drain, then keep watching for stray beats before the verdict.
      while (pending_elems.size() != 0)
         @(posedge clock);
      repeat (MAX_EXPAND + 8) @(posedge clock);

      if (mismatch_count == 0 && pending_elems.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #(64'd20_000_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
